// ===== hdl/spd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

  // Frame layout
  localparam int unsigned HdrLen = 13;
  localparam int unsigned IdxW   = 4;
  localparam logic [IdxW-1:0] HdrLast = IdxW'(HdrLen - 1);
  localparam logic [IdxW-1:0] LenLoIdx = 4'd5;
  localparam logic [7:0]  SyncByte = 8'h40;
  localparam logic [7:0]  TermByte = 8'h0A;
  localparam logic [15:0] LenBias  = 16'd7;
  localparam logic [15:0] TimeoutReset = 16'd2;
  localparam logic [15:0] IdleMax  = 16'hFFFF;

  // Input kinds
  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef enum logic [2:0] {
    EV_HEADER = 3'd0,
    EV_BODY   = 3'd1,
    EV_SYNC   = 3'd2,
    EV_DEAD   = 3'd3,
    EV_FINAL  = 3'd4
  } event_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [7:0]  seq_count;
    logic [7:0]  message_type;
    logic        packet_end;
    logic        terminator_ok;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/spd_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spd_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire spd_pkg::in_item_t in_item,
  input  wire logic             take,
  output logic                  item_valid,
  output spd_pkg::in_item_t     item
);
  import spd_pkg::*;

  // Accept a new word whenever the register is empty or drains this cycle
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_value,
  input  wire logic              fire,
  input  wire spd_pkg::in_item_t item,
  output logic                   res_valid,
  output spd_pkg::result_t       res
);
  import spd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RESYNC = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t          phase, phase_next;
  logic [IdxW-1:0] header_index, header_index_next;
  logic [15:0]     body_remaining, body_remaining_next;
  logic [15:0]     idle_ticks, idle_ticks_next;
  logic            byte_seen, byte_seen_next;
  logic [15:0]     timeout_ticks;
  logic [7:0]      hdr [HdrLen];

  logic [15:0]     hdr_len;
  logic [15:0]     rem_dec;
  logic [IdxW-1:0] term_idx;
  logic [7:0]      term_byte;
  logic [7:0]      first_byte;
  logic            hdr_we;
  logic [7:0]      b;

  assign b = item.rx_byte;

  // Length field; a short frame may close on the current word
  assign hdr_len    = {hdr[6], hdr[5]};
  assign first_byte = hdr[0];
  assign rem_dec    = (body_remaining != 16'd0) ? body_remaining - 16'd1 : body_remaining;
  assign term_idx   = {1'b0, hdr_len[2:0]} + LenLoIdx;
  assign term_byte  = (term_idx == HdrLast) ? b : hdr[term_idx];

  // Decode one word
  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    body_remaining_next = body_remaining;
    idle_ticks_next     = idle_ticks;
    byte_seen_next      = byte_seen;
    hdr_we              = 1'b0;
    res_valid           = 1'b0;
    res                 = '0;
    res.event_res       = EV_HEADER;
    res.packet_length   = hdr_len;
    res.source_id       = hdr[7];
    res.dest_id         = hdr[8];
    res.seq_count       = hdr[9];
    res.message_type    = hdr[10];

    if (item.action == ActTick) begin
      if (byte_seen && idle_ticks != IdleMax) begin
        idle_ticks_next = idle_ticks + 16'd1;
      end
    end else if (byte_seen && idle_ticks >= timeout_ticks) begin
      // Link dead: drop the word and restart
      phase_next          = PH_HEADER;
      header_index_next   = '0;
      body_remaining_next = '0;
      byte_seen_next      = 1'b0;
      idle_ticks_next     = '0;
      res_valid           = 1'b1;
      res                 = '0;
      res.event_res       = EV_DEAD;
    end else begin
      byte_seen_next  = 1'b1;
      idle_ticks_next = '0;
      unique case (phase)
        PH_RESYNC: begin
          if (b == TermByte) begin
            phase_next        = PH_HEADER;
            header_index_next = '0;
          end
        end
        PH_BODY: begin
          body_remaining_next = rem_dec;
          res_valid           = 1'b1;
          res.data_byte       = b;
          if (rem_dec == 16'd0) begin
            phase_next        = PH_HEADER;
            header_index_next = '0;
            res.event_res     = EV_FINAL;
            res.packet_end    = 1'b1;
            res.terminator_ok = (b == TermByte);
          end else begin
            res.event_res     = EV_BODY;
          end
        end
        default: begin
          hdr_we = 1'b1;
          if (header_index == HdrLast) begin
            header_index_next = '0;
            res_valid         = 1'b1;
            if (first_byte != SyncByte) begin
              phase_next    = (first_byte == TermByte) ? PH_HEADER : PH_RESYNC;
              res           = '0;
              res.event_res = EV_SYNC;
            end else if (hdr_len > LenBias) begin
              body_remaining_next = hdr_len - LenBias;
              phase_next          = PH_BODY;
            end else begin
              body_remaining_next = '0;
              phase_next          = PH_HEADER;
              res.packet_end      = 1'b1;
              res.terminator_ok   = (term_byte == TermByte);
            end
          end else begin
            header_index_next = header_index + IdxW'(1);
          end
        end
      endcase
    end
  end

  // Hold parser state and the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_index   <= '0;
      body_remaining <= '0;
      idle_ticks     <= '0;
      byte_seen      <= 1'b0;
      timeout_ticks  <= TimeoutReset;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_value;
      end
      if (fire) begin
        phase          <= phase_next;
        header_index   <= header_index_next;
        body_remaining <= body_remaining_next;
        idle_ticks     <= idle_ticks_next;
        byte_seen      <= byte_seen_next;
      end
    end
  end

  // Capture header bytes
  always_ff @(posedge clk) begin
    if (fire && hdr_we) begin
      hdr[header_index] <= b;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire spd_pkg::result_t res,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spd_pkg::result_t      out_res
);
  import spd_pkg::*;

  // Free when empty or the held word leaves this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sonar_packet_deframer.sv =====
// Length-prefixed packet deframer with a link watchdog.
// Input stream: s_axis_tuser[0] = 0 for a received byte (s_axis_tdata), 1 for a
// timebase tick. Ticks only advance the silence counter and give no output.
// Output stream: one word per header, body byte, final byte, loss of sync or
// link-dead report. m_axis_tuser carries the event code, m_axis_tlast marks the
// word that closes a packet.
// Configuration: cfg_data loads the timeout in ticks whenever cfg_valid is high
// (cfg_ready is always high); write it only while the stream is idle.
// Path: an accepted word is held in the input register and decoded into the
// output register when that can take a result; its result is offered from there.
// Throughput: one input word per cycle while m_axis_tready is high, set by the
// single decode step between the input register and the output register.
// Reset: timeout returns to 2 ticks, the parser returns to header collection,
// both registers empty. Header bytes are not cleared.
// Stall: while m_axis_tready is low the output word holds, one more word waits
// in the input register, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module sonar_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic [0:0]  s_axis_tuser,  // [0] action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] data_byte, [23:8] packet_length, [31:24] source_id, [39:32] dest_id,
  // [47:40] seq_count, [55:48] message_type, [56] terminator_ok, [63:57] zero
  output logic [63:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,  // [2:0] event_res
  output logic             m_axis_tlast,  // packet_end
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import spd_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     fire;
  logic     can_load;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign cfg_ready = 1'b1;
  assign s_item.action  = s_axis_tuser[0];
  assign s_item.rx_byte = s_axis_tdata;

  // Decode a word when one is held and the output register can take a result
  assign fire = item_valid && can_load;

  spd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (s_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  spd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  spd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result word
  assign m_axis_tdata = {7'd0, out_res.terminator_ok, out_res.message_type,
                         out_res.seq_count, out_res.dest_id, out_res.source_id,
                         out_res.packet_length, out_res.data_byte};
  assign m_axis_tuser = out_res.event_res;
  assign m_axis_tlast = out_res.packet_end;

endmodule

`default_nettype wire
